@@ hw/rtl/ltd_pkg.sv @@
package ltd_pkg;

    // Number of base-93 digits allowed in one length field.
    localparam int MAX_DIGITS = 5;

    localparam logic [7:0] FIRST_DIGIT = 8'd33;
    localparam logic [7:0] LAST_DIGIT  = 8'd126;
    localparam logic [7:0] SPACE_CHAR  = 8'd32;
    localparam logic [7:0] CHAR_M      = 8'h6d;
    localparam logic [7:0] CHAR_S      = 8'h73;
    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [6:0] DIGIT_BASE  = 7'd93;

    // Result kinds.
    localparam logic [1:0] KIND_FRAMING   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
    localparam logic [1:0] KIND_SEPARATOR = 2'd2;
    localparam logic [1:0] KIND_IGNORED   = 2'd3;

    // End-of-message status codes; the stop reasons reuse the second and third.
    localparam logic [2:0] END_CLEAN      = 3'd0;
    localparam logic [2:0] END_BAD_PREFIX = 3'd1;
    localparam logic [2:0] END_BAD_LENGTH = 3'd2;
    localparam logic [2:0] END_IN_LENGTH  = 3'd3;
    localparam logic [2:0] END_IN_PAYLOAD = 3'd4;
    localparam logic [2:0] END_IN_PREFIX  = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [30:0] string_length;
        logic        stream_ended;
        logic [2:0]  end_status;
    } res_t;

endpackage

@@ hw/rtl/length_prefixed_token_deframer.sv @@
// Deframer for messages of the form "ms:" followed by records of a base-93
// length (one to five digits, least significant first), a space, the payload
// bytes and one separator byte. One byte enters per clock cycle while in_stall
// is low, and every byte yields exactly one result transaction, which is
// registered before it appears on the output. All the parsing for a byte is
// combinational from the current parser state: the only arithmetic is a 27x7
// multiply-add into the length sum and a constant multiply by 93 of the place
// weight. A two-entry output stage (result register plus skid register)
// keeps accepting bytes while a result is held up downstream; in_stall rises
// only when both entries are full. Malformed input (wrong prefix, bad digit,
// zero, too long or oversized length) stops parsing, and all later bytes of
// the message are reported as ignored. The byte flagged as last reports why
// the message ended and returns the parser to the start of a new message.
module length_prefixed_token_deframer
    import ltd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [30:0] string_length,
    output logic        stream_ended,
    output logic [2:0]  end_status
);

    // Parser phases.
    localparam logic [2:0] PH_PREFIX_M  = 3'd0;
    localparam logic [2:0] PH_PREFIX_S  = 3'd1;
    localparam logic [2:0] PH_PREFIX_C  = 3'd2;
    localparam logic [2:0] PH_LENGTH    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD   = 3'd4;
    localparam logic [2:0] PH_SEPARATOR = 3'd5;
    localparam logic [2:0] PH_STOPPED   = 3'd6;

    localparam logic [2:0] DIGIT_LIMIT = 3'(MAX_DIGITS);

    // Parser state.
    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  digit_count_reg, digit_count_next;
    logic [26:0] place_weight_reg, place_weight_next;
    logic [32:0] length_sum_reg, length_sum_next;
    logic [30:0] payload_left_reg, payload_left_next;
    logic [30:0] held_length_reg, held_length_next;
    logic [2:0]  stop_reason_reg, stop_reason_next;

    // Output stage: result register and skid register behind it.
    logic        out_valid_reg, out_valid_next;
    res_t        res_reg, res_next;
    logic        skid_valid_reg, skid_valid_next;
    res_t        skid_reg, skid_next;

    logic        accept;
    logic        out_take;
    res_t        res_new;
    logic [6:0]  digit_value;
    logic [33:0] digit_product;
    logic [33:0] weight_product;
    logic [2:0]  end_phase;

    // The skid register is the only thing that can hold the input back.
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    assign digit_value    = 7'(in_byte - FIRST_DIGIT);
    assign digit_product  = 34'(place_weight_reg) * 34'(digit_value);
    assign weight_product = 34'(place_weight_reg) * 34'(DIGIT_BASE);

    // One byte of parsing.
    always_comb
    begin
        phase_next        = phase_reg;
        digit_count_next  = digit_count_reg;
        place_weight_next = place_weight_reg;
        length_sum_next   = length_sum_reg;
        payload_left_next = payload_left_reg;
        held_length_next  = held_length_reg;
        stop_reason_next  = stop_reason_reg;

        res_new               = '0;
        res_new.kind          = KIND_FRAMING;
        res_new.stream_ended  = last_byte;

        case (phase_reg)
            PH_PREFIX_M, PH_PREFIX_S, PH_PREFIX_C:
            begin
                if ((phase_reg == PH_PREFIX_M && in_byte == CHAR_M) ||
                    (phase_reg == PH_PREFIX_S && in_byte == CHAR_S) ||
                    (phase_reg == PH_PREFIX_C && in_byte == CHAR_COLON))
                begin
                    if (phase_reg == PH_PREFIX_C)
                    begin
                        phase_next        = PH_LENGTH;
                        digit_count_next  = '0;
                        place_weight_next = 27'd1;
                        length_sum_next   = '0;
                    end
                    else
                    begin
                        phase_next = phase_reg + 3'd1;
                    end
                end
                else
                begin
                    phase_next       = PH_STOPPED;
                    stop_reason_next = END_BAD_PREFIX;
                    res_new.kind     = KIND_IGNORED;
                end
            end
            PH_LENGTH:
            begin
                if (in_byte == SPACE_CHAR)
                begin
                    // A length must have digits, be nonzero and fit in 31 bits.
                    if (digit_count_reg == '0 || length_sum_reg == '0 ||
                        length_sum_reg[32:31] != 2'b00)
                    begin
                        phase_next       = PH_STOPPED;
                        stop_reason_next = END_BAD_LENGTH;
                        res_new.kind     = KIND_IGNORED;
                    end
                    else
                    begin
                        held_length_next  = length_sum_reg[30:0];
                        payload_left_next = length_sum_reg[30:0];
                        phase_next        = PH_PAYLOAD;
                    end
                end
                else if (!(in_byte inside {[FIRST_DIGIT:LAST_DIGIT]}) ||
                         digit_count_reg >= DIGIT_LIMIT)
                begin
                    phase_next       = PH_STOPPED;
                    stop_reason_next = END_BAD_LENGTH;
                    res_new.kind     = KIND_IGNORED;
                end
                else
                begin
                    length_sum_next  = length_sum_reg + digit_product[32:0];
                    digit_count_next = digit_count_reg + 3'd1;
                    if (digit_count_reg + 3'd1 < DIGIT_LIMIT)
                    begin
                        place_weight_next = weight_product[26:0];
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res_new.kind     = KIND_PAYLOAD;
                res_new.out_byte = in_byte;
                if (payload_left_reg != '0)
                begin
                    payload_left_next = payload_left_reg - 31'd1;
                end
                if (payload_left_reg <= 31'd1)
                begin
                    phase_next = PH_SEPARATOR;
                end
            end
            PH_SEPARATOR:
            begin
                res_new.kind          = KIND_SEPARATOR;
                res_new.string_length = held_length_reg;
                phase_next            = PH_LENGTH;
                digit_count_next      = '0;
                place_weight_next     = 27'd1;
                length_sum_next       = '0;
            end
            default:
            begin
                phase_next   = PH_STOPPED;
                res_new.kind = KIND_IGNORED;
            end
        endcase

        // On the last byte, classify where the message ended and start over.
        end_phase = phase_next;
        if (last_byte)
        begin
            if (end_phase == PH_STOPPED)
            begin
                res_new.end_status = stop_reason_next;
            end
            else if (end_phase == PH_LENGTH)
            begin
                res_new.end_status = (digit_count_next == '0) ? END_CLEAN : END_IN_LENGTH;
            end
            else if (end_phase inside {PH_PAYLOAD, PH_SEPARATOR})
            begin
                res_new.end_status = END_IN_PAYLOAD;
            end
            else
            begin
                res_new.end_status = END_IN_PREFIX;
            end
            phase_next        = PH_PREFIX_M;
            digit_count_next  = '0;
            place_weight_next = 27'd1;
            length_sum_next   = '0;
            payload_left_next = '0;
            held_length_next  = '0;
            stop_reason_next  = END_CLEAN;
        end
    end

    // Output stage steering. The skid entry only fills while the result
    // register is held, and it always drains before a new byte is taken.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        res_next        = res_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                res_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_valid_next = 1'b1;
                res_next       = res_new;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PREFIX_M;
            digit_count_reg  <= '0;
            place_weight_reg <= 27'd1;
            length_sum_reg   <= '0;
            payload_left_reg <= '0;
            held_length_reg  <= '0;
            stop_reason_reg  <= END_CLEAN;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= phase_next;
                digit_count_reg  <= digit_count_next;
                place_weight_reg <= place_weight_next;
                length_sum_reg   <= length_sum_next;
                payload_left_reg <= payload_left_next;
                held_length_reg  <= held_length_next;
                stop_reason_reg  <= stop_reason_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payloads carry no reset.
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = res_reg.kind;
    assign out_byte      = res_reg.out_byte;
    assign string_length = res_reg.string_length;
    assign stream_ended  = res_reg.stream_ended;
    assign end_status    = res_reg.end_status;

endmodule

@@ verif/deframer_result_check.sv @@
module deframer_result_check
    import ltd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  out_byte,
    input  logic [30:0] string_length,
    input  logic        stream_ended,
    input  logic [2:0]  end_status,
    output int          mismatch_count,
    output int          results_due,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        AWAIT_M,
        AWAIT_S,
        AWAIT_COLON,
        IN_LENGTH,
        IN_PAYLOAD,
        AT_SEPARATOR,
        HALTED
    } parse_phase_e;

    parse_phase_e phase;
    logic [2:0]   digits_taken;
    logic [26:0]  weight;
    logic [32:0]  length_acc;
    logic [30:0]  bytes_left;
    logic [30:0]  record_length;
    logic [2:0]   halt_reason;

    res_t due_results[$];

    task start_length_field();
        digits_taken = '0;
        weight       = 27'd1;
        length_acc   = '0;
    endtask

    task clear_parser();
        phase         = AWAIT_M;
        start_length_field();
        bytes_left    = '0;
        record_length = '0;
        halt_reason   = END_CLEAN;
    endtask

    task halt_parse(input logic [2:0] reason);
        phase       = HALTED;
        halt_reason = reason;
    endtask

    // Advances the parser by one byte and returns the result that byte causes.
    task deframe_byte(input logic [7:0] b, input logic fin, output res_t r);
        logic [7:0] want;
        r = '0;
        case (phase)
            AWAIT_M, AWAIT_S, AWAIT_COLON:
            begin
                want = (phase == AWAIT_M) ? CHAR_M
                     : (phase == AWAIT_S) ? CHAR_S : CHAR_COLON;
                if (b == want)
                begin
                    if (phase == AWAIT_COLON)
                    begin
                        phase = IN_LENGTH;
                        start_length_field();
                    end
                    else
                    begin
                        phase = parse_phase_e'(phase + 3'd1);
                    end
                end
                else
                begin
                    halt_parse(END_BAD_PREFIX);
                    r.kind = KIND_IGNORED;
                end
            end
            IN_LENGTH:
            begin
                if (b == SPACE_CHAR)
                begin
                    if (digits_taken == 0 || length_acc == 0 || length_acc > 33'h07FFFFFFF)
                    begin
                        halt_parse(END_BAD_LENGTH);
                        r.kind = KIND_IGNORED;
                    end
                    else
                    begin
                        record_length = length_acc[30:0];
                        bytes_left    = length_acc[30:0];
                        phase         = IN_PAYLOAD;
                    end
                end
                else if (b < FIRST_DIGIT || b > LAST_DIGIT || digits_taken >= MAX_DIGITS)
                begin
                    halt_parse(END_BAD_LENGTH);
                    r.kind = KIND_IGNORED;
                end
                else
                begin
                    length_acc   = length_acc + weight * (b - FIRST_DIGIT);
                    digits_taken = digits_taken + 3'd1;
                    if (digits_taken < MAX_DIGITS)
                    begin
                        weight = weight * DIGIT_BASE;
                    end
                end
            end
            IN_PAYLOAD:
            begin
                r.kind     = KIND_PAYLOAD;
                r.out_byte = b;
                if (bytes_left != 0)
                begin
                    bytes_left = bytes_left - 31'd1;
                end
                if (bytes_left == 0)
                begin
                    phase = AT_SEPARATOR;
                end
            end
            AT_SEPARATOR:
            begin
                r.kind          = KIND_SEPARATOR;
                r.string_length = record_length;
                phase           = IN_LENGTH;
                start_length_field();
            end
            default:
            begin
                phase  = HALTED;
                r.kind = KIND_IGNORED;
            end
        endcase

        if (fin)
        begin
            r.stream_ended = 1'b1;
            if (phase == HALTED)
            begin
                r.end_status = halt_reason;
            end
            else if (phase == IN_LENGTH)
            begin
                r.end_status = (digits_taken == 0) ? END_CLEAN : END_IN_LENGTH;
            end
            else if (phase == IN_PAYLOAD || phase == AT_SEPARATOR)
            begin
                r.end_status = END_IN_PAYLOAD;
            end
            else
            begin
                r.end_status = END_IN_PREFIX;
            end
            clear_parser();
        end
    endtask

    task report_fault(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t ns: %s", $realtime, what);
        end
    endtask

    // The result side is checked before the byte of the same edge is parsed, so
    // a result can never be matched against the byte that is entering with it.
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want_r;
        if (!rst_n)
        begin
            clear_parser();
            due_results.delete();
            results_due = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.kind          = kind;
                got.out_byte      = out_byte;
                got.string_length = string_length;
                got.stream_ended  = stream_ended;
                got.end_status    = end_status;
                results_seen++;
                if (due_results.size() == 0)
                begin
                    report_fault($sformatf("result %0d arrived with none outstanding",
                                           results_seen));
                end
                else
                begin
                    want_r = due_results.pop_front();
                    if (got.kind !== want_r.kind || got.out_byte !== want_r.out_byte ||
                        got.string_length !== want_r.string_length ||
                        got.stream_ended !== want_r.stream_ended ||
                        got.end_status !== want_r.end_status)
                    begin
                        report_fault($sformatf({"result %0d: expected kind=%0d byte=%02h ",
                            "len=%0d end=%0b st=%0d, got kind=%0d byte=%02h ",
                            "len=%0d end=%0b st=%0d"},
                            results_seen, want_r.kind, want_r.out_byte, want_r.string_length,
                            want_r.stream_ended, want_r.end_status, got.kind, got.out_byte,
                            got.string_length, got.stream_ended, got.end_status));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                deframe_byte(in_byte, last_byte, want_r);
                due_results.push_back(want_r);
            end
            results_due = due_results.size();
        end
    end

endmodule

@@ verif/length_prefixed_token_deframer_tb.sv @@
module length_prefixed_token_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ltd_pkg::*;

    // Timing of the run. The fixed limit is far beyond the slowest legal run:
    // about 1700 bytes, each delayed at most by a short sender gap and receiver
    // stall, plus one long hold-off and two full drains.
    localparam int      CLK_HALF    = 5;
    localparam int      RESET_CYCLES = 6;
    localparam int      BYTE_TARGET = 1700;
    localparam int      CALM_FROM   = 1450;
    localparam int      HOLD_AT     = 400;
    localparam int      DRAIN_AT    = 900;
    localparam int      LONG_HOLD   = 64;
    localparam int      TAIL_CYCLES = 8;
    localparam longint  LIMIT_NS    = 1_000_000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [30:0] string_length;
    logic        stream_ended;
    logic [2:0]  end_status;

    int mismatch_count;
    int results_due;
    int results_seen;

    // Knobs shared between the sender and the receiver processes.
    bit sender_idles;
    bit receiver_idles;
    bit hold_request;

    int bytes_sent;
    int messages_sent;

    // Bytes of the message being put together; the last one carries last_byte.
    logic [7:0] msg_q[$];

    always #CLK_HALF clk = ~clk;

    length_prefixed_token_deframer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .out_byte      (out_byte),
        .string_length (string_length),
        .stream_ended  (stream_ended),
        .end_status    (end_status)
    );

    // The checker watches both channels beside the block, keeps its own parser
    // and compares every result transaction with the oldest one outstanding.
    deframer_result_check result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .out_byte       (out_byte),
        .string_length  (string_length),
        .stream_ended   (stream_ended),
        .end_status     (end_status),
        .mismatch_count (mismatch_count),
        .results_due    (results_due),
        .results_seen   (results_seen)
    );

    // Receiver. It stalls in short random bursts while idling is enabled, and
    // on request it holds off for a long stretch so that the two-entry output
    // stage fills up and the block has to stall the sender.
    initial
    begin
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offers one byte and returns at the falling edge after it was taken. The
    // caller either offers the next byte at that edge, which keeps in_valid
    // high without a glitch, or lowers in_valid itself.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        last_byte <= fin;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_message();
        foreach (msg_q[i])
        begin
            send_byte(msg_q[i], i == msg_q.size() - 1);
        end
        messages_sent++;
        msg_q.delete();
    endtask

    // Stops offering bytes until every outstanding result has come out.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (results_due != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic int min_digits(input longint unsigned value);
        int n;
        n = 1;
        while (value >= 93)
        begin
            value = value / 93;
            n++;
        end
        return n;
    endfunction

    // Base-93 length, least significant digit first, padded with zero digits
    // when more digits are asked for than the value needs.
    function automatic void put_length(input longint unsigned value, input int ndigits);
        for (int i = 0; i < ndigits; i++)
        begin
            msg_q.push_back(8'(FIRST_DIGIT + value % 93));
            value = value / 93;
        end
    endfunction

    function automatic void put_prefix();
        msg_q.push_back(CHAR_M);
        msg_q.push_back(CHAR_S);
        msg_q.push_back(CHAR_COLON);
    endfunction

    function automatic void put_digit();
        msg_q.push_back(8'($urandom_range(FIRST_DIGIT, LAST_DIGIT)));
    endfunction

    // One complete record. Lengths are mostly short to keep the run fast, with
    // an occasional longer one that can need two digits.
    function automatic void put_record();
        int len;
        int nd;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 200) : $urandom_range(1, 8);
        nd  = min_digits(len);
        if ($urandom_range(0, 3) == 0)
        begin
            nd = $urandom_range(nd, MAX_DIGITS);
        end
        put_length(len, nd);
        msg_q.push_back(SPACE_CHAR);
        repeat (len) msg_q.push_back(8'($urandom));
        msg_q.push_back(8'($urandom));
    endfunction

    // Most messages are well formed with random content and one of several
    // endings; the rest are broken on purpose, cut off inside the prefix, or
    // pure noise.
    function automatic void build_random_message();
        int form;
        int count;
        int pos;
        longint unsigned value;
        logic [7:0] b;
        form = $urandom_range(0, 99);
        if (form >= 95)
        begin
            count = $urandom_range(1, 8);
            repeat (count) msg_q.push_back(8'($urandom));
            return;
        end
        put_prefix();
        if (form >= 87)
        begin
            // Message ends inside the prefix, or right after it.
            count = $urandom_range(1, 3);
            while (msg_q.size() > count)
            begin
                void'(msg_q.pop_back());
            end
            return;
        end
        count = (form < 70) ? $urandom_range(1, 4) : $urandom_range(0, 2);
        repeat (count) put_record();
        if (form < 70)
        begin
            case ($urandom_range(0, 9))
                5, 6:
                begin
                    // Cut off inside a length.
                    count = $urandom_range(1, MAX_DIGITS);
                    repeat (count) put_digit();
                end
                7, 8:
                begin
                    // A large length that is accepted, then the message is
                    // cut off in its payload; the top of the range sometimes.
                    value = ($urandom_range(0, 3) == 0) ? 64'h7FFFFFFF
                                                        : $urandom_range(1, 32'h7FFFFFFF);
                    put_length(value, min_digits(value));
                    msg_q.push_back(SPACE_CHAR);
                    count = $urandom_range(0, 3);
                    repeat (count) msg_q.push_back(8'($urandom));
                end
                9:
                begin
                    // Cut off just before the separator.
                    put_record();
                    void'(msg_q.pop_back());
                end
                default:
                begin
                end
            endcase
            return;
        end
        case ($urandom_range(0, 4))
            0:
            begin
                pos = $urandom_range(0, 2);
                do
                begin
                    b = 8'($urandom);
                end
                while (b == msg_q[pos]);
                msg_q[pos] = b;
            end
            1:
            begin
                // Unprintable byte in a length, after a few good digits.
                count = $urandom_range(0, 3);
                repeat (count) put_digit();
                msg_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                     : 8'($urandom_range(127, 255)));
            end
            2:
            begin
                repeat (MAX_DIGITS + 1) put_digit();
            end
            3:
            begin
                // Zero length: a bare space, or zero digits only.
                count = $urandom_range(0, MAX_DIGITS);
                repeat (count) msg_q.push_back(FIRST_DIGIT);
                msg_q.push_back(SPACE_CHAR);
            end
            default:
            begin
                // Length just over the limit, the largest five-digit value, or
                // anything in between.
                case ($urandom_range(0, 2))
                    0:       value = 64'h80000000;
                    1:       value = 64'd6956883692;
                    default: value = 64'h80000000 + longint'($urandom);
                endcase
                put_length(value, MAX_DIGITS);
                msg_q.push_back(SPACE_CHAR);
            end
        endcase
        // Bytes after a stop are only reported as ignored.
        count = $urandom_range(0, 4);
        repeat (count) msg_q.push_back(8'($urandom));
    endfunction

    // Stimulus and verdict.
    initial
    begin
        bit held_once;
        bit drained_once;
        held_once      = 1'b0;
        drained_once   = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_byte        = 8'h00;
        last_byte      = 1'b0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_request   = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed messages. A clean record with payload byte FF and a zero
        // separator, the separator being the last byte.
        msg_q = '{CHAR_M, CHAR_S, CHAR_COLON, 8'h22, SPACE_CHAR, 8'hFF, 8'h00};
        send_message();
        // Wrong first byte, then a byte that is ignored.
        msg_q = '{8'h78, 8'h80};
        send_message();
        // Message ends inside the prefix.
        msg_q = '{CHAR_M};
        send_message();
        // Largest five-digit length, which is over the limit.
        msg_q = '{CHAR_M, CHAR_S, CHAR_COLON, LAST_DIGIT, LAST_DIGIT, LAST_DIGIT,
                  LAST_DIGIT, LAST_DIGIT, SPACE_CHAR};
        send_message();
        // Unprintable digit.
        msg_q = '{CHAR_M, CHAR_S, CHAR_COLON, 8'h7F};
        send_message();
        // Space with no digits before it.
        msg_q = '{CHAR_M, CHAR_S, CHAR_COLON, SPACE_CHAR};
        send_message();
        // Message ends inside a length.
        msg_q = '{CHAR_M, CHAR_S, CHAR_COLON, 8'h23};
        send_message();

        // Random messages. Part way through, the receiver holds off for a long
        // stretch while bytes keep coming, and later the sender waits for a
        // full drain. The last part runs with no idling on either side.
        while (bytes_sent < BYTE_TARGET)
        begin
            if (!held_once && bytes_sent >= HOLD_AT)
            begin
                hold_request = 1'b1;
                held_once    = 1'b1;
            end
            if (!drained_once && bytes_sent >= DRAIN_AT)
            begin
                pause_until_drained();
                @(negedge clk);
                drained_once = 1'b1;
            end
            if (bytes_sent >= CALM_FROM)
            begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end
            build_random_message();
            send_message();
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d bytes in %0d messages, %0d results compared, %0d mismatches.",
                 bytes_sent, messages_sent, results_seen, mismatch_count);
        $display("Mix: clean and cut-off records, bad prefixes and lengths, noise, long hold.");
        if (mismatch_count == 0 && results_due == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(LIMIT_NS);
        $display("Timed out with %0d results still outstanding.", results_due);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
